FILE: rtl/besa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// besa_pkg
// Shared constants, types and register codes for the ball edge / servo aim
// block.
// ----------------------------------------------------------------------------
package besa_pkg;

    localparam int IMAGE_WIDTH  = 80;
    localparam int IMAGE_HEIGHT = 60;
    localparam int COL_W        = $clog2(IMAGE_WIDTH);
    localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

    // search window (edge column is the black pixel's column)
    localparam int WIN_ROW_LO = 10;
    localparam int WIN_ROW_HI = 49;
    localparam int WIN_COL_LO = 10;
    localparam int WIN_COL_HI = 69;

    localparam int PIX_W      = 8;
    localparam int X_W        = 7;
    localparam int Y_W        = 6;
    localparam int DUTY_W     = 8;
    localparam int GAIN_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;

    localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;
    localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;

    // divide by 3 as multiply by reciprocal, exact for 0..255
    localparam int SUM_Y_W    = Y_W + 2;
    localparam int DIV3_MUL   = 171;
    localparam int DIV3_SHIFT = 9;
    localparam int PROD_W     = 16;

    localparam int DUTY_S_W = DUTY_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SETPOINT_X     = 3'd0,
        CFG_SETPOINT_Y     = 3'd1,
        CFG_NEUTRAL_DUTY_X = 3'd2,
        CFG_NEUTRAL_DUTY_Y = 3'd3,
        CFG_GAIN_SHIFT     = 3'd4
    } t_cfg_idx;

    localparam logic [X_W-1:0]    RST_SETPOINT_X = 7'd40;
    localparam logic [Y_W-1:0]    RST_SETPOINT_Y = 6'd40;
    localparam logic [DUTY_W-1:0] RST_NEUTRAL_X  = 8'd17;
    localparam logic [DUTY_W-1:0] RST_NEUTRAL_Y  = 8'd20;
    localparam logic [GAIN_W-1:0] RST_GAIN       = 3'd3;

    typedef struct packed {
        logic [X_W-1:0]    setpoint_x;
        logic [Y_W-1:0]    setpoint_y;
        logic [DUTY_W-1:0] neutral_duty_x;
        logic [DUTY_W-1:0] neutral_duty_y;
        logic [GAIN_W-1:0] gain_shift;
    } t_cfg;

    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
    } t_point;

    typedef struct packed {
        logic [X_W:0]       sum_x;
        logic [SUM_Y_W-1:0] sum_y;
        logic               edge_seen;
    } t_snap;

    typedef struct packed {
        logic [X_W-1:0]    center_x;
        logic [Y_W-1:0]    center_y;
        logic [DUTY_W-1:0] duty_x;
        logic [DUTY_W-1:0] duty_y;
        logic              edge_seen;
    } t_result;

endpackage

FILE: rtl/besa_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// besa_track
// Input register, raster position, edge detect and extreme point tracking.
// Emits a snapshot of the point sums on the last pixel of each frame.
// ----------------------------------------------------------------------------
module besa_track import besa_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_frame_start,
    output logic             o_snap_valid,
    output t_snap            o_snap,
    input  logic             i_snap_take
);

    logic             r_in_v;
    logic [PIX_W-1:0] r_in_pix;
    logic             r_in_fs;

    logic [PIX_W-1:0] r_prev, n_prev;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    t_point           r_top, n_top, r_bot, n_bot, r_left, n_left, r_right, n_right;
    logic             r_seeded, n_seeded;
    logic             r_snap_v;
    t_snap            r_snap, n_snap;

    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col, col_m1;
    logic             seed_eff, in_win, is_edge, is_last, fire;
    t_point           ep;

    assign fire    = r_in_v && (!r_snap_v || i_snap_take);
    assign o_ready = !r_in_v || fire;

    always_comb begin
        row      = r_in_fs ? '0 : r_row;
        col      = r_in_fs ? '0 : r_col;
        seed_eff = r_in_fs ? 1'b0 : r_seeded;
        col_m1   = col - COL_W'(1);
        ep.x     = col_m1[X_W-1:0];
        ep.y     = row[Y_W-1:0];

        in_win  = (col >= COL_W'(WIN_COL_LO + 1)) && (col <= COL_W'(WIN_COL_HI + 1)) &&
                  (row >= ROW_W'(WIN_ROW_LO)) && (row <= ROW_W'(WIN_ROW_HI));
        is_edge = in_win && (r_prev == PIX_BLACK) && (r_in_pix == PIX_WHITE);
        is_last = (row == ROW_W'(IMAGE_HEIGHT - 1)) && (col == COL_W'(IMAGE_WIDTH - 1));

        n_top   = r_top;
        n_bot   = r_bot;
        n_left  = r_left;
        n_right = r_right;
        if (is_edge) begin
            if (!seed_eff) begin
                n_top   = ep;
                n_bot   = ep;
                n_left  = ep;
                n_right = ep;
            end else begin
                // top: last edge on the first edge row; others: first wins
                if (r_top.y >= ep.y) n_top = ep;
                if (r_left.x > ep.x) n_left = ep;
                if (r_bot.y < ep.y) n_bot = ep;
                if (r_right.x < ep.x) n_right = ep;
            end
        end

        n_snap.sum_x     = {1'b0, n_top.x} + {1'b0, n_bot.x};
        n_snap.sum_y     = SUM_Y_W'(n_top.y) + SUM_Y_W'(n_bot.y) + SUM_Y_W'(n_right.y);
        n_snap.edge_seen = seed_eff || is_edge;

        n_prev = r_in_pix;
        if (is_last) begin
            n_row    = '0;
            n_col    = '0;
            n_seeded = 1'b0;
        end else begin
            n_seeded = seed_eff || is_edge;
            if (col == COL_W'(IMAGE_WIDTH - 1)) begin
                n_col = '0;
                n_row = row + ROW_W'(1);
            end else begin
                n_col = col + COL_W'(1);
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_prev   <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_top    <= '0;
            r_bot    <= '0;
            r_left   <= '0;
            r_right  <= '0;
            r_seeded <= 1'b0;
            r_snap_v <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_v <= 1'b1;
            end else if (fire) begin
                r_in_v <= 1'b0;
            end
            if (fire) begin
                r_prev   <= n_prev;
                r_row    <= n_row;
                r_col    <= n_col;
                r_top    <= n_top;
                r_bot    <= n_bot;
                r_left   <= n_left;
                r_right  <= n_right;
                r_seeded <= n_seeded;
            end
            if (fire && is_last) begin
                r_snap_v <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_pix <= i_pixel;
            r_in_fs  <= i_frame_start;
        end
        if (fire && is_last) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_v;
    assign o_snap       = r_snap;

endmodule

FILE: rtl/besa_aim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// besa_aim
// Center from point sums (stage A), servo duties with saturation into the
// output register (stage B).
// ----------------------------------------------------------------------------
module besa_aim import besa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_snap_valid,
    input  t_snap   i_snap,
    output logic    o_snap_take,
    output logic    o_valid,
    output t_result o_result,
    input  logic    i_ready
);

    logic              r_a_v;
    logic [X_W-1:0]    r_a_cx;
    logic [Y_W-1:0]    r_a_cy;
    logic              r_a_seen;
    logic              r_o_v;
    t_result           r_o, n_o;

    logic              o_free, a_free;
    logic [PROD_W-1:0] prod;
    logic [X_W-1:0]    diff_x, sh_x;
    logic [Y_W-1:0]    diff_y, sh_y;
    logic signed [DUTY_S_W-1:0] dx, dy;

    assign o_free      = !r_o_v || i_ready;
    assign a_free      = !r_a_v || o_free;
    assign o_snap_take = i_snap_valid && a_free;

    assign prod = PROD_W'(i_snap.sum_y) * PROD_W'(DIV3_MUL);

    function automatic logic [DUTY_W-1:0] sat_duty(input logic signed [DUTY_S_W-1:0] v);
        logic [DUTY_W-1:0] res;
        if (v < 0) res = '0;
        else if (v > DUTY_S_W'(255)) res = '1;
        else res = v[DUTY_W-1:0];
        return res;
    endfunction

    always_comb begin
        if (r_a_cx > i_cfg.setpoint_x) diff_x = r_a_cx - i_cfg.setpoint_x;
        else                           diff_x = i_cfg.setpoint_x - r_a_cx;
        if (r_a_cy > i_cfg.setpoint_y) diff_y = r_a_cy - i_cfg.setpoint_y;
        else                           diff_y = i_cfg.setpoint_y - r_a_cy;
        sh_x = diff_x >> i_cfg.gain_shift;
        sh_y = diff_y >> i_cfg.gain_shift;

        // x servo is inverted
        if (r_a_cx > i_cfg.setpoint_x)
            dx = $signed(DUTY_S_W'(i_cfg.neutral_duty_x)) - $signed(DUTY_S_W'(sh_x));
        else
            dx = $signed(DUTY_S_W'(i_cfg.neutral_duty_x)) + $signed(DUTY_S_W'(sh_x));
        if (r_a_cy > i_cfg.setpoint_y)
            dy = $signed(DUTY_S_W'(i_cfg.neutral_duty_y)) + $signed(DUTY_S_W'(sh_y));
        else
            dy = $signed(DUTY_S_W'(i_cfg.neutral_duty_y)) - $signed(DUTY_S_W'(sh_y));

        n_o.center_x  = r_a_cx;
        n_o.center_y  = r_a_cy;
        n_o.duty_x    = sat_duty(dx);
        n_o.duty_y    = sat_duty(dy);
        n_o.edge_seen = r_a_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (a_free) r_a_v <= i_snap_valid;
            if (o_free) r_o_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_a_cx   <= i_snap.sum_x[X_W:1];
            r_a_cy   <= prod[DIV3_SHIFT +: Y_W];
            r_a_seen <= i_snap.edge_seen;
        end
        if (o_free && r_a_v) begin
            r_o <= n_o;
        end
    end

    assign o_valid  = r_o_v;
    assign o_result = r_o;

endmodule

FILE: rtl/ball_edge_extremes_servo_aim_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_edge_extremes_servo_aim_core
// Ball edge extremes in a binarized frame and servo duty aiming.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one pixel per request, raster order; tuser[0] marks the
//   first pixel of a frame. Every pixel is taken, one per cycle while tready is high.
//   Master stream: one result request per frame, issued after the last pixel
//   (row IMAGE_HEIGHT-1, column IMAGE_WIDTH-1) with center, duties, edge flag.
//   Config port: write i_cfg_data to register i_cfg_index when i_cfg_we is
//   high; unknown indexes are ignored. Write only while the block is idle.
// Timing:
//   Throughput is one pixel per cycle while tready is high. After the edge that
//   takes the last pixel into the input register, a result passes through the
//   tracking stage into the snapshot register, the center stage (divide by 3
//   multiplier) and the duty stage into the output register to the master side.
// Reset: synchronous, active low; points, position, config return to defaults.
// Stall: results queue in the pipeline registers; input tready falls only
//   once those are all occupied, so pixels keep flowing while one result waits.
// ----------------------------------------------------------------------------
module ball_edge_extremes_servo_aim_core import besa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [TDATA_IN_W-1:0]   i_s_tdata,   // [7:0] pixel
    input  logic [0:0]              i_s_tuser,   // [0] frame_start
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [TDATA_OUT_W-1:0]  o_m_tdata,   // [6:0] center_x, [12:7] center_y,
                                                 // [20:13] duty_x, [28:21] duty_y, zeros
    output logic [0:0]              o_m_tuser,   // [0] edge_seen
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg    r_cfg;
    logic    snap_valid, snap_take;
    t_snap   snap;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint_x     <= RST_SETPOINT_X;
            r_cfg.setpoint_y     <= RST_SETPOINT_Y;
            r_cfg.neutral_duty_x <= RST_NEUTRAL_X;
            r_cfg.neutral_duty_y <= RST_NEUTRAL_Y;
            r_cfg.gain_shift     <= RST_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SETPOINT_X:     r_cfg.setpoint_x     <= i_cfg_data[X_W-1:0];
                CFG_SETPOINT_Y:     r_cfg.setpoint_y     <= i_cfg_data[Y_W-1:0];
                CFG_NEUTRAL_DUTY_X: r_cfg.neutral_duty_x <= i_cfg_data[DUTY_W-1:0];
                CFG_NEUTRAL_DUTY_Y: r_cfg.neutral_duty_y <= i_cfg_data[DUTY_W-1:0];
                CFG_GAIN_SHIFT:     r_cfg.gain_shift     <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    besa_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_s_tvalid),
        .o_ready       (o_s_tready),
        .i_pixel       (i_s_tdata[PIX_W-1:0]),
        .i_frame_start (i_s_tuser[0]),
        .o_snap_valid  (snap_valid),
        .o_snap        (snap),
        .i_snap_take   (snap_take)
    );

    besa_aim u_aim (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_snap_valid (snap_valid),
        .i_snap       (snap),
        .o_snap_take  (snap_take),
        .o_valid      (o_m_tvalid),
        .o_result     (result),
        .i_ready      (i_m_tready)
    );

    assign o_m_tdata = {3'b000, result.duty_y, result.duty_x,
                        result.center_y, result.center_x};
    assign o_m_tuser = result.edge_seen;

endmodule

FILE: rtl/besa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// besa_checker
// Port-level checks for the ball edge / servo aim core, bound to the top.
// ----------------------------------------------------------------------------
module besa_checker import besa_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [TDATA_OUT_W-1:0] o_m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // nothing queued downstream means pixels are always taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // center never exceeds the search window's last column and last row
    a_center_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[6:0] <= 7'd69) && (o_m_tdata[12:7] <= 6'd49))
        else $error("center outside window");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind ball_edge_extremes_servo_aim_core besa_checker u_besa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: tb/ball_edge_extremes_servo_aim_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_edge_extremes_servo_aim_core_tb
// Self-checking bench for the ball edge extremes / servo aim core.
// ----------------------------------------------------------------------------
// Whole frames are painted into a canvas and streamed one pixel per request.
// A directed list of frames covers blank frames, single edges at the window
// corners, near misses just outside the window, tie rules between edges,
// duty saturation at the register extremes, frames without a frame start and
// frames restarted half way. Random frames follow: black disks on white with
// noise, pure noise, blank and restarted frames, under three idling phases
// and changing register settings. An aim tracker in the bench predicts each
// result that the list does not pin; all are compared field by field in order.
// ----------------------------------------------------------------------------
module ball_edge_extremes_servo_aim_core_tb;
    import besa_pkg::*;

    localparam int FRAME_PX   = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int PIPE_SLACK = 8;
    localparam longint RUN_LIMIT = 64'd60_000_000;

    // result tdata layout
    localparam int CY_LSB = X_W;
    localparam int DX_LSB = X_W + Y_W;
    localparam int DY_LSB = DX_LSB + DUTY_W;

    typedef enum logic [2:0] {
        SHOT_BLANK,
        SHOT_EDGE,
        SHOT_NEAR,
        SHOT_RUNS,
        SHOT_BALL,
        SHOT_NO_FS,
        SHOT_RESTART
    } t_shot_kind;

    typedef struct packed {
        t_shot_kind kind;
        logic [6:0] a;       // column of edge or disk center
        logic [5:0] b;       // row of edge or disk center
        logic [4:0] r;       // disk radius
        logic       new_cfg;
        t_cfg       cfg;
        logic       pinned;  // want holds the result read straight off the spec
        t_result    want;
    } t_shot;

    localparam t_shot SHOTS [12] = '{
        // nothing seen since reset: center (0,0)
        '{kind: SHOT_BLANK, pinned: 1'b1,
          want: '{7'd0, 6'd0, 8'd22, 8'd15, 1'b0}, default: '0},
        '{kind: SHOT_EDGE, a: 7'd10, b: 6'd10, pinned: 1'b1,
          want: '{7'd10, 6'd10, 8'd20, 8'd17, 1'b1}, default: '0},
        '{kind: SHOT_EDGE, a: 7'd69, b: 6'd49, pinned: 1'b1,
          want: '{7'd69, 6'd49, 8'd14, 8'd21, 1'b1}, default: '0},
        // only near misses: old points stay, flag low
        '{kind: SHOT_NEAR, pinned: 1'b1,
          want: '{7'd69, 6'd49, 8'd14, 8'd21, 1'b0}, default: '0},
        '{kind: SHOT_RUNS, default: '0},
        '{kind: SHOT_BALL, a: 7'd40, b: 6'd30, r: 5'd12, default: '0},
        // saturation low on x, high on y
        '{kind: SHOT_EDGE, a: 7'd69, b: 6'd49, new_cfg: 1'b1,
          cfg: '{7'd0, 6'd0, 8'd0, 8'd255, 3'd0}, pinned: 1'b1,
          want: '{7'd69, 6'd49, 8'd0, 8'd255, 1'b1}, default: '0},
        // saturation high on x, low on y
        '{kind: SHOT_EDGE, a: 7'd10, b: 6'd10, new_cfg: 1'b1,
          cfg: '{7'd79, 6'd59, 8'd255, 8'd0, 3'd0}, pinned: 1'b1,
          want: '{7'd10, 6'd10, 8'd255, 8'd0, 1'b1}, default: '0},
        '{kind: SHOT_BALL, a: 7'd20, b: 6'd45, r: 5'd9, new_cfg: 1'b1,
          cfg: '{7'd40, 6'd30, 8'd128, 8'd128, 3'd7}, default: '0},
        '{kind: SHOT_NO_FS, a: 7'd60, b: 6'd15, r: 5'd7, default: '0},
        '{kind: SHOT_RESTART, a: 7'd35, b: 6'd20, r: 5'd10, default: '0},
        '{kind: SHOT_BALL, a: 7'd5, b: 6'd5, r: 5'd20, new_cfg: 1'b1,
          cfg: '{RST_SETPOINT_X, RST_SETPOINT_Y, RST_NEUTRAL_X, RST_NEUTRAL_Y,
                 RST_GAIN}, default: '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [TDATA_IN_W-1:0]  i_s_tdata = '0;   // [7:0] pixel
    logic [0:0]             i_s_tuser = '0;   // [0] frame_start
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] o_m_tdata;        // [6:0] center_x, [12:7] center_y,
                                              // [20:13] duty_x, [28:21] duty_y
    logic [0:0]             o_m_tuser;        // [0] edge_seen
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    ball_edge_extremes_servo_aim_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---- aim tracker state ----
    t_cfg           aim_cfg = '{RST_SETPOINT_X, RST_SETPOINT_Y, RST_NEUTRAL_X,
                                RST_NEUTRAL_Y, RST_GAIN};
    logic [PIX_W-1:0] trk_prev = '0;
    int             trk_row = 0;
    int             trk_col = 0;
    t_point         pt_top = '0;
    t_point         pt_bot = '0;
    t_point         pt_lft = '0;
    t_point         pt_rgt = '0;
    bit             trk_seeded = 1'b0;

    t_result        aim_due [$];
    // one entry per directed frame, taken in order at each frame end
    bit             pin_on_q [$];
    t_result        pin_res_q [$];
    int             errors = 0;
    int             src_idle = 0;
    int             snk_idle = 0;
    logic [PIX_W-1:0] canvas [IMAGE_HEIGHT][IMAGE_WIDTH];

    function automatic int clamp_duty(input int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    // Advances the tracker by one pixel; returns 1 when the pixel closes a frame.
    function automatic bit track_pixel(input logic [PIX_W-1:0] pix, input bit fs,
                                       output t_result res);
        int r, c, ex, cx, cy, dx, dy;
        res = '0;
        if (fs) begin
            trk_row = 0;
            trk_col = 0;
            trk_seeded = 1'b0;
        end
        r = trk_row;
        c = trk_col;
        // edge column is that of the black pixel, one left of the current one
        if (c >= WIN_COL_LO + 1 && c <= WIN_COL_HI + 1 &&
            r >= WIN_ROW_LO && r <= WIN_ROW_HI &&
            trk_prev == PIX_BLACK && pix == PIX_WHITE) begin
            ex = c - 1;
            if (!trk_seeded) begin
                pt_top = '{X_W'(ex), Y_W'(r)};
                pt_bot = pt_top;
                pt_lft = pt_top;
                pt_rgt = pt_top;
                trk_seeded = 1'b1;
            end
            if (int'(pt_top.y) >= r) pt_top = '{X_W'(ex), Y_W'(r)};
            if (int'(pt_lft.x) > ex) pt_lft = '{X_W'(ex), Y_W'(r)};
            if (int'(pt_bot.y) < r) pt_bot = '{X_W'(ex), Y_W'(r)};
            if (int'(pt_rgt.x) < ex) pt_rgt = '{X_W'(ex), Y_W'(r)};
        end
        trk_prev = pix;

        if (r == IMAGE_HEIGHT - 1 && c == IMAGE_WIDTH - 1) begin
            cx = (int'(pt_top.x) + int'(pt_bot.x)) / 2;
            cy = (int'(pt_top.y) + int'(pt_bot.y) + int'(pt_rgt.y)) / 3;
            // x direction is inverted
            if (cx > int'(aim_cfg.setpoint_x))
                dx = int'(aim_cfg.neutral_duty_x)
                     - ((cx - int'(aim_cfg.setpoint_x)) >> aim_cfg.gain_shift);
            else
                dx = int'(aim_cfg.neutral_duty_x)
                     + ((int'(aim_cfg.setpoint_x) - cx) >> aim_cfg.gain_shift);
            if (cy > int'(aim_cfg.setpoint_y))
                dy = int'(aim_cfg.neutral_duty_y)
                     + ((cy - int'(aim_cfg.setpoint_y)) >> aim_cfg.gain_shift);
            else
                dy = int'(aim_cfg.neutral_duty_y)
                     - ((int'(aim_cfg.setpoint_y) - cy) >> aim_cfg.gain_shift);
            res.center_x  = X_W'(cx);
            res.center_y  = Y_W'(cy);
            res.duty_x    = DUTY_W'(clamp_duty(dx));
            res.duty_y    = DUTY_W'(clamp_duty(dy));
            res.edge_seen = trk_seeded;
            trk_seeded = 1'b0;
            trk_row = 0;
            trk_col = 0;
            return 1'b1;
        end
        if (c + 1 >= IMAGE_WIDTH) begin
            trk_col = 0;
            trk_row = r + 1;
        end else begin
            trk_col = c + 1;
        end
        return 1'b0;
    endfunction

    // ---- pixel side monitor ----
    always @(posedge i_clk) begin : px_watch
        t_result got;
        t_result pin_res;
        bit      pin_on;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (track_pixel(i_s_tdata[PIX_W-1:0], i_s_tuser[0], got)) begin
                pin_on  = 1'b0;
                pin_res = '0;
                if (pin_on_q.size() != 0) begin
                    pin_on  = pin_on_q.pop_front();
                    pin_res = pin_res_q.pop_front();
                end
                if (pin_on)
                    aim_due.push_back(pin_res);
                else
                    aim_due.push_back(got);
            end
        end
    end

    function automatic void chk(input string fld, input int want, input int got);
        if (want != got) begin
            $display("%0t  %s mismatch: expected %0d, got %0d", $time, fld, want, got);
            errors++;
        end
    endfunction

    // ---- result side: check and random stall ----
    always @(posedge i_clk) begin : aim_sink
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (aim_due.size() == 0) begin
                $display("%0t  unexpected result: expected none, got tdata %h tuser %b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = aim_due.pop_front();
                chk("center_x", int'(want.center_x), int'(o_m_tdata[CY_LSB-1:0]));
                chk("center_y", int'(want.center_y), int'(o_m_tdata[DX_LSB-1:CY_LSB]));
                chk("duty_x", int'(want.duty_x), int'(o_m_tdata[DY_LSB-1:DX_LSB]));
                chk("duty_y", int'(want.duty_y),
                    int'(o_m_tdata[DY_LSB+DUTY_W-1:DY_LSB]));
                chk("edge_seen", int'(want.edge_seen), int'(o_m_tuser[0]));
            end
        end
        i_m_tready <= (snk_idle == 0) || ($urandom_range(99) >= snk_idle);
    end

    // ---- drivers ----
    task automatic send_px(input logic [PIX_W-1:0] pix, input logic fs);
        while (src_idle != 0 && $urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tuser  <= fs;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic stream_canvas(input int n, input bit with_fs);
        for (int k = 0; k < n; k++)
            send_px(canvas[k / IMAGE_WIDTH][k % IMAGE_WIDTH], with_fs && k == 0);
    endtask

    // stop sending, let every pending result drain, then let the pipe empty
    task automatic settle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (aim_due.size() != 0) @(posedge i_clk);
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic apply_cfg(input t_cfg c);
        // an index past the last register must be ignored
        if ($urandom_range(1))
            cfg_put(CFG_IDX_W'(CFG_GAIN_SHIFT) + CFG_IDX_W'($urandom_range(1, 3)),
                    CFG_DATA_W'($urandom_range(255)));
        cfg_put(CFG_SETPOINT_X, CFG_DATA_W'(c.setpoint_x));
        cfg_put(CFG_SETPOINT_Y, CFG_DATA_W'(c.setpoint_y));
        cfg_put(CFG_NEUTRAL_DUTY_X, c.neutral_duty_x);
        cfg_put(CFG_NEUTRAL_DUTY_Y, c.neutral_duty_y);
        cfg_put(CFG_GAIN_SHIFT, CFG_DATA_W'(c.gain_shift));
        i_cfg_we <= 1'b0;
        aim_cfg = c;
    endtask

    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.setpoint_x     = X_W'($urandom_range(IMAGE_WIDTH - 1));
        c.setpoint_y     = Y_W'($urandom_range(IMAGE_HEIGHT - 1));
        c.neutral_duty_x = DUTY_W'($urandom_range(255));
        c.neutral_duty_y = DUTY_W'($urandom_range(255));
        c.gain_shift     = GAIN_W'($urandom_range(7));
        return c;
    endfunction

    // mostly clean black/white, sometimes any value
    function automatic logic [PIX_W-1:0] noise_px();
        if ($urandom_range(3) == 0) return PIX_W'($urandom_range(255));
        return $urandom_range(1) ? PIX_WHITE : PIX_BLACK;
    endfunction

    task automatic paint_fill(input logic [PIX_W-1:0] v);
        for (int y = 0; y < IMAGE_HEIGHT; y++)
            for (int x = 0; x < IMAGE_WIDTH; x++)
                canvas[y][x] = v;
    endtask

    task automatic paint_disk(input int x0, input int y0, input int rad);
        for (int y = 0; y < IMAGE_HEIGHT; y++)
            for (int x = 0; x < IMAGE_WIDTH; x++)
                if ((x - x0) * (x - x0) + (y - y0) * (y - y0) <= rad * rad)
                    canvas[y][x] = PIX_BLACK;
    endtask

    task automatic paint_ball();
        paint_fill(PIX_WHITE);
        paint_disk($urandom_range(IMAGE_WIDTH - 1), $urandom_range(IMAGE_HEIGHT - 1),
                   $urandom_range(1, 25));
        if ($urandom_range(9) < 3)
            paint_disk($urandom_range(IMAGE_WIDTH - 1), $urandom_range(IMAGE_HEIGHT - 1),
                       $urandom_range(1, 8));
        repeat ($urandom_range(20))
            canvas[$urandom_range(IMAGE_HEIGHT - 1)][$urandom_range(IMAGE_WIDTH - 1)]
                = noise_px();
    endtask

    task automatic random_frame();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            paint_fill($urandom_range(1) ? PIX_WHITE : PIX_BLACK);
            stream_canvas(FRAME_PX, 1'b1);
        end else if (pick < 16) begin
            for (int y = 0; y < IMAGE_HEIGHT; y++)
                for (int x = 0; x < IMAGE_WIDTH; x++)
                    canvas[y][x] = noise_px();
            stream_canvas(FRAME_PX, 1'b1);
        end else if (pick < 24) begin
            // frame start lands at a random point of an unfinished frame
            paint_ball();
            stream_canvas($urandom_range(1, FRAME_PX - 1), 1'b1);
            paint_ball();
            stream_canvas(FRAME_PX, 1'b1);
        end else begin
            paint_ball();
            stream_canvas(FRAME_PX, $urandom_range(9) != 0);
        end
    endtask

    // ---- main sequence ----
    initial begin : run
        t_shot s;
        int    n_frames;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle = 31;
        snk_idle = 88;
        for (int i = 0; i < $size(SHOTS); i++) begin
            s = SHOTS[i];
            if (s.new_cfg) begin
                settle();
                apply_cfg(s.cfg);
            end
            pin_on_q.push_back(s.pinned);
            pin_res_q.push_back(s.want);
            paint_fill(PIX_WHITE);
            case (s.kind)
                SHOT_EDGE: begin
                    canvas[s.b][s.a] = PIX_BLACK;
                end
                SHOT_NEAR: begin
                    canvas[20][WIN_COL_LO - 1] = PIX_BLACK;
                    canvas[20][WIN_COL_HI + 1] = PIX_BLACK;
                    canvas[WIN_ROW_LO - 1][30] = PIX_BLACK;
                    canvas[WIN_ROW_HI + 1][30] = PIX_BLACK;
                    canvas[30][30] = 8'h01;
                    canvas[30][40] = PIX_BLACK;
                    canvas[30][41] = 8'hFE;
                    canvas[25][IMAGE_WIDTH - 1] = PIX_BLACK;
                end
                SHOT_RUNS: begin
                    // two on the top row, a tie on the right column, one grey pixel on the bottom row
                    canvas[20][30] = PIX_BLACK;
                    canvas[20][50] = PIX_BLACK;
                    canvas[35][15] = PIX_BLACK;
                    canvas[35][60] = PIX_BLACK;
                    canvas[40][60] = PIX_BLACK;
                    canvas[40][65] = 8'h80;
                end
                SHOT_BALL, SHOT_NO_FS, SHOT_RESTART: begin
                    paint_disk(s.a, s.b, s.r);
                end
                default: begin
                end
            endcase
            if (s.kind == SHOT_NO_FS) begin
                stream_canvas(FRAME_PX, 1'b0);
            end else if (s.kind == SHOT_RESTART) begin
                stream_canvas(FRAME_PX / 2, 1'b1);
                paint_fill(PIX_WHITE);
                stream_canvas(FRAME_PX, 1'b1);
            end else begin
                stream_canvas(FRAME_PX, 1'b1);
            end
        end

        for (int ph = 0; ph < 3; ph++) begin
            settle();
            apply_cfg(rand_cfg());
            case (ph)
                0: begin src_idle = 31; snk_idle = 88; n_frames = 20; end
                1: begin src_idle = 88; snk_idle = 31; n_frames = 6; end
                default: begin src_idle = 0; snk_idle = 0; n_frames = 20; end
            endcase
            for (int f = 0; f < n_frames; f++) begin
                if (f != 0 && $urandom_range(4) == 0) begin
                    settle();
                    apply_cfg(rand_cfg());
                end
                random_frame();
            end
        end

        settle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: ball_edge_extremes_servo_aim_core.f
rtl/besa_pkg.sv
rtl/besa_track.sv
rtl/besa_aim.sv
rtl/ball_edge_extremes_servo_aim_core.sv
rtl/besa_checker.sv
tb/ball_edge_extremes_servo_aim_core_tb.sv
